// ===== rtl/rdx_pkg.sv =====
// ============================================================================
// rdx_pkg
// Shared widths, codes, channel defaults and the microcode program of the
// radix converter.
// ============================================================================
package rdx_pkg;

   // Defaults for the top-level parameters.
   localparam int unsigned HEX_CHARS_DEF      = 8;
   localparam int unsigned BIN_OUT_DIGITS_DEF = 19;

   // Field widths.
   localparam int unsigned MODE_W   = 3;
   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned LEN_W    = 4;
   localparam int unsigned RESULT_W = 60;
   localparam int unsigned STATUS_W = 2;

   // Positive operand width: a positive 32-bit signed value fits in 31 bits.
   localparam int unsigned POS_W = VALUE_W - 1;

   // Reciprocal of ten for the divide-by-ten step: q = (n * RECIP10) >> RECIP_SHIFT.
   localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
   localparam int unsigned RECIP_SHIFT = 35;
   localparam int unsigned PROD_W      = POS_W + 32;
   localparam int unsigned QUOT_W      = PROD_W - RECIP_SHIFT;

   // Conversion modes.
   localparam logic [MODE_W-1:0] MODE_BIN2DEC = 3'd0;
   localparam logic [MODE_W-1:0] MODE_OCT2DEC = 3'd1;
   localparam logic [MODE_W-1:0] MODE_HEX2DEC = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DEC2BIN = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DEC2OCT = 3'd4;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_NOT_BIN  = 2'd1,
      ST_BIN_OVF  = 2'd2,
      ST_BAD_MODE = 2'd3
   } status_type;

   // Datapath operations selected by a control word.
   typedef enum logic [2:0] {
      OP_NOP      = 3'd0,
      OP_INIT     = 3'd1,
      OP_DEC_MUL  = 3'd2,
      OP_DEC_ACC  = 3'd3,
      OP_FIN      = 3'd4,
      OP_HEX_ACC  = 3'd5,
      OP_BIN_CHK  = 3'd6,
      OP_BASE_ACC = 3'd7
   } op_type;

   // Jump conditions; a jump that is not taken falls through to the next step.
   typedef enum logic [2:0] {
      C_NEVER       = 3'd0,
      C_ALWAYS      = 3'd1,
      C_MODE        = 3'd2,
      C_N_ZERO      = 3'd3,
      C_N_NEXT_NZ   = 3'd4,
      C_CNT_ZERO    = 3'd5,
      C_CNT_NEXT_NZ = 3'd6,
      C_OVF         = 3'd7
   } cond_type;

   typedef logic [3:0] ucode_addr_type;

   localparam ucode_addr_type A_INIT      = 4'd0;
   localparam ucode_addr_type A_DEC_TEST  = 4'd1;
   localparam ucode_addr_type A_DEC_MUL   = 4'd2;
   localparam ucode_addr_type A_DEC_ACC   = 4'd3;
   localparam ucode_addr_type A_FIN       = 4'd4;
   localparam ucode_addr_type A_HEX_TEST  = 4'd5;
   localparam ucode_addr_type A_HEX_ACC   = 4'd6;
   localparam ucode_addr_type A_HEX_END   = 4'd7;
   localparam ucode_addr_type A_BIN_CHK   = 4'd8;
   localparam ucode_addr_type A_BASE_TEST = 4'd9;
   localparam ucode_addr_type A_BASE_ACC  = 4'd10;
   localparam ucode_addr_type A_BASE_END  = 4'd11;

   typedef struct packed {
      op_type         op;
      cond_type       cond;
      ucode_addr_type target;
   } ucode_word_type;

   // Status from the datapath that the sequencer tests for its jumps.
   typedef struct packed {
      logic           n_zero;
      logic           n_next_nz;
      logic           cnt_zero;
      logic           cnt_next_nz;
      logic           ovf;
      logic           out_blocked;
      ucode_addr_type mode_target;
   } rdx_flags_type;

   function automatic ucode_word_type ucode_rom(input ucode_addr_type addr);
      ucode_word_type w;
      unique case (addr)
         A_INIT:      w = '{OP_INIT,     C_MODE,        A_INIT};
         A_DEC_TEST:  w = '{OP_NOP,      C_N_ZERO,      A_FIN};
         A_DEC_MUL:   w = '{OP_DEC_MUL,  C_NEVER,       A_INIT};
         A_DEC_ACC:   w = '{OP_DEC_ACC,  C_N_NEXT_NZ,   A_DEC_MUL};
         A_FIN:       w = '{OP_FIN,      C_NEVER,       A_INIT};
         A_HEX_TEST:  w = '{OP_NOP,      C_CNT_ZERO,    A_FIN};
         A_HEX_ACC:   w = '{OP_HEX_ACC,  C_CNT_NEXT_NZ, A_HEX_ACC};
         A_HEX_END:   w = '{OP_NOP,      C_ALWAYS,      A_FIN};
         A_BIN_CHK:   w = '{OP_BIN_CHK,  C_OVF,         A_FIN};
         A_BASE_TEST: w = '{OP_NOP,      C_N_ZERO,      A_FIN};
         A_BASE_ACC:  w = '{OP_BASE_ACC, C_N_NEXT_NZ,   A_BASE_ACC};
         A_BASE_END:  w = '{OP_NOP,      C_ALWAYS,      A_FIN};
         default:     w = '{OP_FIN,      C_NEVER,       A_INIT};
      endcase
      return w;
   endfunction

   // Entry point of the routine for each mode.
   function automatic ucode_addr_type mode_entry(input logic [MODE_W-1:0] mode);
      ucode_addr_type a;
      unique case (mode)
         MODE_BIN2DEC, MODE_OCT2DEC: a = A_DEC_TEST;
         MODE_HEX2DEC:               a = A_HEX_TEST;
         MODE_DEC2BIN:               a = A_BIN_CHK;
         MODE_DEC2OCT:               a = A_BASE_TEST;
         default:                    a = A_FIN;
      endcase
      return a;
   endfunction

endpackage

// ===== rtl/rdx_req_if.sv =====
// ============================================================================
// rdx_req_if
// Request channel of the radix converter: valid, ready and one request.
// ============================================================================
interface rdx_req_if #(
   parameter int unsigned HEX_CHARS = rdx_pkg::HEX_CHARS_DEF
);
   import rdx_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [MODE_W-1:0]          mode;
   logic signed [VALUE_W-1:0]  value;
   logic [8*HEX_CHARS-1:0]     hex_chars;
   logic [LEN_W-1:0]           hex_length;

   modport source (output valid, mode, value, hex_chars, hex_length, input ready);
   modport sink   (input valid, mode, value, hex_chars, hex_length, output ready);
endinterface

// ===== rtl/rdx_rsp_if.sv =====
// ============================================================================
// rdx_rsp_if
// Result channel of the radix converter: valid, ready and one result.
// ============================================================================
interface rdx_rsp_if;
   import rdx_pkg::*;

   logic                valid;
   logic                ready;
   logic [RESULT_W-1:0] result;
   logic [STATUS_W-1:0] status;

   modport source (output valid, result, status, input ready);
   modport sink   (input valid, result, status, output ready);
endinterface

// ===== rtl/radix_converter_top.sv =====
// ============================================================================
// radix_converter_top
// A non-positive operand, an empty string or an invalid mode skips the digit
// steps, and mode 3 on overflow goes from its check straight to the finish.
// One request is in flight; the next beat can be taken once the result is
// registered. Reset idles the sequencer and empties the result register.
// ============================================================================
module radix_converter_top #(
   parameter int unsigned HEX_CHARS      = rdx_pkg::HEX_CHARS_DEF,
   parameter int unsigned BIN_OUT_DIGITS = rdx_pkg::BIN_OUT_DIGITS_DEF
) (
   input logic      clock,
   input logic      reset,
   rdx_req_if.sink  req_chan,
   rdx_rsp_if.source rsp_chan
);
   import rdx_pkg::*;

   // -------------------------------------------------------------------------
   // The block is a small microcoded machine. The sequencer walks a fixed
   // program, one control word per cycle while the finishing step does not
   // stall; each word picks one datapath operation and one jump condition. The
   // datapath below holds the operand, an accumulator and a weight, and adds
   // one digit times the weight per digit step.
   //
   // Decimal-digit modes (0 and 1) peel one decimal digit in two steps:
   // the first step registers n times a reciprocal of ten, the second forms
   // the quotient and remainder and accumulates. Modes 3 and 4 peel one
   // binary or octal digit per cycle with a shift, and the weight is multiplied
   // by ten each step. Mode 2 consumes one ASCII character per cycle from the
   // low byte of a shift register.
   // -------------------------------------------------------------------------

   // Request held for the duration of the program.
   logic [MODE_W-1:0]      mode_ff, mode_in;
   logic [POS_W-1:0]       n_ff, n_in;
   logic [8*HEX_CHARS-1:0] chars_ff, chars_in;
   logic [LEN_W-1:0]       cnt_ff, cnt_in;

   // Working registers.
   logic [RESULT_W-1:0]    acc_ff, acc_in;
   logic [RESULT_W-1:0]    w_ff, w_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   status_type             status_ff, status_in;

   // Result register toward the sink.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RESULT_W-1:0]    rsp_result_ff, rsp_result_in;
   status_type             rsp_status_ff, rsp_status_in;

   logic                   accept;
   logic                   running;
   ucode_word_type         ctl;
   rdx_flags_type          flags;

   logic [QUOT_W-1:0]      quot;
   logic [POS_W-1:0]       quot_x10;
   logic [POS_W-1:0]       rem_full;
   logic [POS_W-1:0]       n_shift;
   logic [3:0]             digit;
   logic [RESULT_W-1:0]    digit_w;
   logic                   is_bin;

   // Value of one upper-case hex character; anything else counts as zero.
   function automatic logic [3:0] hex_digit(input logic [7:0] c);
      logic [3:0] d;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d = 4'(c - 8'h37);
      end else begin
         d = 4'd0;
      end
      return d;
   endfunction

   rdx_sequencer u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .flags   (flags),
      .running (running),
      .ctl     (ctl)
   );

   // A new request is taken only while no program runs; a result that still
   // waits in the output register does not hold the request side back.
   assign req_chan.ready = !running;
   assign accept         = req_chan.valid && req_chan.ready;

   // Divide-by-ten pieces: the registered product gives the quotient, and the
   // remainder is what is left after subtracting ten times the quotient.
   assign quot     = prod_ff[PROD_W-1:RECIP_SHIFT];
   assign quot_x10 = POS_W'({quot, 3'b000}) + POS_W'({quot, 1'b0});
   assign rem_full = n_ff - quot_x10;

   assign is_bin  = (mode_ff == MODE_DEC2BIN);
   assign n_shift = is_bin ? (n_ff >> 1) : (n_ff >> 3);

   // The digit that the current step adds, times the current weight.
   always_comb begin
      unique case (ctl.op)
         OP_DEC_ACC:  digit = rem_full[3:0];
         OP_HEX_ACC:  digit = hex_digit(chars_ff[7:0]);
         OP_BASE_ACC: digit = is_bin ? {3'b000, n_ff[0]} : {1'b0, n_ff[2:0]};
         default:     digit = 4'd0;
      endcase
   end
   assign digit_w = w_ff * RESULT_W'(digit);

   // Flags for the sequencer's jumps.
   always_comb begin
      flags.n_zero      = (n_ff == '0);
      flags.n_next_nz   = (ctl.op == OP_DEC_ACC) ? (quot != '0) : (n_shift != '0);
      flags.cnt_zero    = (cnt_ff == '0);
      flags.cnt_next_nz = (cnt_ff > LEN_W'(1));
      flags.ovf         = ((n_ff >> BIN_OUT_DIGITS) != '0);
      flags.out_blocked = rsp_valid_ff && !rsp_chan.ready;
      flags.mode_target = mode_entry(mode_ff);
   end

   always_comb begin
      mode_in       = mode_ff;
      n_in          = n_ff;
      chars_in      = chars_ff;
      cnt_in        = cnt_ff;
      acc_in        = acc_ff;
      w_in          = w_ff;
      prod_in       = prod_ff;
      status_in     = status_ff;
      rsp_result_in = rsp_result_ff;
      rsp_status_in = rsp_status_ff;

      // A beat taken by the sink empties the result register.
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      if (accept) begin
         mode_in  = req_chan.mode;
         // Non-positive operands convert as zero.
         n_in     = (!req_chan.value[VALUE_W-1] && req_chan.value != '0)
                    ? req_chan.value[POS_W-1:0] : '0;
         chars_in = req_chan.hex_chars;
         cnt_in   = (req_chan.hex_length > LEN_W'(HEX_CHARS))
                    ? LEN_W'(HEX_CHARS) : req_chan.hex_length;
      end

      if (running) begin
         unique case (ctl.op)
            OP_NOP: begin
            end
            OP_INIT: begin
               acc_in    = '0;
               w_in      = RESULT_W'(1);
               status_in = (mode_ff > MODE_DEC2OCT) ? ST_BAD_MODE : ST_OK;
            end
            OP_DEC_MUL: begin
               prod_in = PROD_W'(n_ff) * PROD_W'(RECIP10);
            end
            OP_DEC_ACC: begin
               acc_in = acc_ff + digit_w;
               w_in   = (mode_ff == MODE_BIN2DEC) ? (w_ff << 1) : (w_ff << 3);
               n_in   = POS_W'(quot);
               // Mode 0 keeps going after a bad digit; the flag zeroes the result.
               if (mode_ff == MODE_BIN2DEC && digit > 4'd1) begin
                  status_in = ST_NOT_BIN;
               end
            end
            OP_HEX_ACC: begin
               acc_in   = acc_ff + digit_w;
               w_in     = w_ff << 4;
               chars_in = chars_ff >> 8;
               cnt_in   = cnt_ff - LEN_W'(1);
            end
            OP_BIN_CHK: begin
               if (flags.ovf) begin
                  status_in = ST_BIN_OVF;
               end
            end
            OP_BASE_ACC: begin
               acc_in = acc_ff + digit_w;
               w_in   = (w_ff << 3) + (w_ff << 1);
               n_in   = n_shift;
            end
            OP_FIN: begin
               if (!flags.out_blocked) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = status_ff;
                  rsp_result_in = (status_ff == ST_OK) ? acc_ff : '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers need no reset.
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      n_ff          <= n_in;
      chars_ff      <= chars_in;
      cnt_ff        <= cnt_in;
      acc_ff        <= acc_in;
      w_ff          <= w_in;
      prod_ff       <= prod_in;
      status_ff     <= status_in;
      rsp_result_ff <= rsp_result_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.result = rsp_result_ff;
   assign rsp_chan.status = rsp_status_ff;

   // -------------------------------------------------------------------------
   // Assertions
   // -------------------------------------------------------------------------

   // Any failing status carries a zero result.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> (rsp_result_ff == '0))
      else $error("non-ok result beat carries a nonzero result");

   // A freshly loaded result flags an invalid mode exactly when the mode is one.
   a_bad_mode: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |->
         ((mode_ff > MODE_DEC2OCT) == (rsp_status_ff == ST_BAD_MODE)))
      else $error("invalid-mode status does not match the request mode");

   // An overflow status only ever comes from the decimal-to-binary mode.
   a_ovf_mode: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) && rsp_status_ff == ST_BIN_OVF) |-> is_bin)
      else $error("overflow status outside decimal-to-binary mode");

   // A request beat always starts the program on the next cycle.
   a_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> (running && !req_chan.ready))
      else $error("sequencer did not start after a request beat");

endmodule

// ===== rtl/rdx_sequencer.sv =====
// ============================================================================
// rdx_sequencer
// Step counter over the microcode table, with conditional jumps and a stall on
// the finishing step while the result register is full and its beat not taken.
// ============================================================================
module rdx_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  rdx_pkg::rdx_flags_type flags,
   output logic                   running,
   output rdx_pkg::ucode_word_type ctl
);
   import rdx_pkg::*;

   ucode_addr_type pc_ff, pc_in;
   logic           running_ff, running_in;
   logic           taken;

   always_comb begin
      ctl = ucode_rom(pc_ff);

      unique case (ctl.cond)
         C_NEVER:       taken = 1'b0;
         C_ALWAYS:      taken = 1'b1;
         C_MODE:        taken = 1'b1;
         C_N_ZERO:      taken = flags.n_zero;
         C_N_NEXT_NZ:   taken = flags.n_next_nz;
         C_CNT_ZERO:    taken = flags.cnt_zero;
         C_CNT_NEXT_NZ: taken = flags.cnt_next_nz;
         C_OVF:         taken = flags.ovf;
         default:       taken = 1'b0;
      endcase

      pc_in      = pc_ff;
      running_in = running_ff;
      priority if (start) begin
         pc_in      = A_INIT;
         running_in = 1'b1;
      end else if (running_ff) begin
         if (ctl.op == OP_FIN) begin
            // The program ends once the result register takes the beat.
            if (!flags.out_blocked) begin
               running_in = 1'b0;
            end
         end else if (taken) begin
            pc_in = (ctl.cond == C_MODE) ? flags.mode_target : ctl.target;
         end else begin
            pc_in = pc_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff      <= A_INIT;
         running_ff <= 1'b0;
      end else begin
         pc_ff      <= pc_in;
         running_ff <= running_in;
      end
   end

   assign running = running_ff;

endmodule
